FILE: rtl/trcp_pkg.sv
// Package for the text register command parser.
// Character codes, command and number-stage types, default line limit.
// No dependencies.
`default_nettype none

package trcp_pkg;

  localparam int LINE_LIMIT_DEF = 128;

  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [7:0] FIELD_START_POS = 8'd3;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAGE_SKIP   = 2'd0,
    STAGE_NUMBER = 2'd1,
    STAGE_DONE   = 2'd2
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/text_register_command_parser_unit.sv
// Text register command parser, top level.
// Uses trcp_pkg for character codes and state types.
//
// Takes one text byte per word on the in_ channel and emits a parsed
// "RD<x><addr>" or "WR<x><addr> <value>" command on the out_ channel when
// the line's newline arrives. Lines that are too short or carry an unknown
// command produce no word. Positions restart at 0 after LINE_LIMIT bytes.
// Addresses are reduced modulo 256, values modulo 65536; an empty field is 0.
//
// Each byte is captured in an input register, then combinational logic
// updates the line state and, for a complete command, loads the output
// register, from which the result is presented. One byte per cycle is
// accepted sustained while the receiver keeps up; the input register and
// output register keep the input open while a result waits. If the
// receiver stalls, bytes that produce no result still pass; a second result
// waits in the input register until the first is taken.
// After reset (rst_n low, synchronous) both registers are empty and the
// parser sits at line position 0.
`default_nettype none

module text_register_command_parser_unit
  import trcp_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_write,
  output logic [7:0]       out_reg_address,
  output logic [15:0]      out_write_value
);

  localparam logic [7:0] LIMIT = 8'(LINE_LIMIT);

  logic        in_valid_r;
  logic [7:0]  byte_r;

  logic [7:0]  line_pos_r, line_pos_nxt;
  logic [7:0]  first_char_r, first_char_nxt;
  kind_t       kind_r, kind_nxt;
  logic        phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  held_addr_r, held_addr_nxt;

  logic        out_valid_r;
  logic        out_is_write_r, out_is_write_nxt;
  logic [7:0]  out_addr_r, out_addr_nxt;
  logic [15:0] out_value_r, out_value_nxt;

  logic [7:0]  pos;
  kind_t       kind_cur;
  logic [15:0] field_val;
  logic        is_digit;
  logic        is_space;
  logic        emit;
  logic        advance;

  assign field_val = neg_r ? (16'd0 - acc_r) : acc_r;
  assign is_digit  = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_space  = byte_r inside {[CH_TAB:CH_CR], CH_SPACE};
  assign pos       = (line_pos_r >= LIMIT) ? 8'd0 : line_pos_r;

  always_comb begin
    kind_cur = kind_r;
    if (pos == 8'd0) begin
      kind_cur = KIND_NONE;
    end else if (pos == 8'd1) begin
      if (first_char_r == CH_R && byte_r == CH_D) begin
        kind_cur = KIND_READ;
      end else if (first_char_r == CH_W && byte_r == CH_R) begin
        kind_cur = KIND_WRITE;
      end else begin
        kind_cur = KIND_NONE;
      end
    end
  end

  assign emit    = in_valid_r && (byte_r == CH_NL) && (pos >= 8'd2) && (kind_cur != KIND_NONE);
  assign advance = in_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // line state update
  always_comb begin
    line_pos_nxt   = pos + 8'd1;
    first_char_nxt = first_char_r;
    kind_nxt       = kind_cur;
    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    held_addr_nxt  = held_addr_r;

    if (pos == 8'd0) begin
      first_char_nxt = byte_r;
      phase_nxt      = 1'b0;
      held_addr_nxt  = 8'd0;
      stage_nxt      = STAGE_SKIP;
      neg_nxt        = 1'b0;
      acc_nxt        = 16'd0;
    end

    if (byte_r == CH_NL) begin
      line_pos_nxt  = 8'd0;
      kind_nxt      = KIND_NONE;
      phase_nxt     = 1'b0;
      held_addr_nxt = 8'd0;
      stage_nxt     = STAGE_SKIP;
      neg_nxt       = 1'b0;
      acc_nxt       = 16'd0;
    end else if (pos >= FIELD_START_POS && kind_cur != KIND_NONE) begin
      if (kind_cur == KIND_WRITE && !phase_r && byte_r == CH_SPACE) begin
        held_addr_nxt = field_val[7:0];
        phase_nxt     = 1'b1;
        stage_nxt     = STAGE_SKIP;
        neg_nxt       = 1'b0;
        acc_nxt       = 16'd0;
      end else begin
        case (stage_r)
          STAGE_SKIP: begin
            if (is_space) begin
              stage_nxt = STAGE_SKIP;
            end else if (byte_r == CH_PLUS || byte_r == CH_MINUS) begin
              neg_nxt   = (byte_r == CH_MINUS);
              stage_nxt = STAGE_NUMBER;
            end else if (is_digit) begin
              stage_nxt = STAGE_NUMBER;
              acc_nxt   = (acc_r << 3) + (acc_r << 1) + {12'd0, byte_r[3:0]};
            end else begin
              stage_nxt = STAGE_DONE;
            end
          end
          STAGE_NUMBER: begin
            if (is_digit) begin
              acc_nxt = (acc_r << 3) + (acc_r << 1) + {12'd0, byte_r[3:0]};
            end else begin
              stage_nxt = STAGE_DONE;
            end
          end
          default: begin
            stage_nxt = stage_r;
          end
        endcase
      end
    end
  end

  // result formatting
  always_comb begin
    out_is_write_nxt = (kind_cur == KIND_WRITE);
    out_addr_nxt     = field_val[7:0];
    out_value_nxt    = 16'd0;
    if (kind_cur == KIND_WRITE && phase_r) begin
      out_addr_nxt  = held_addr_r;
      out_value_nxt = field_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      line_pos_r   <= 8'd0;
      first_char_r <= 8'd0;
      kind_r       <= KIND_NONE;
      phase_r      <= 1'b0;
      stage_r      <= STAGE_SKIP;
      neg_r        <= 1'b0;
      acc_r        <= 16'd0;
      held_addr_r  <= 8'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        line_pos_r   <= line_pos_nxt;
        first_char_r <= first_char_nxt;
        kind_r       <= kind_nxt;
        phase_r      <= phase_nxt;
        stage_r      <= stage_nxt;
        neg_r        <= neg_nxt;
        acc_r        <= acc_nxt;
        held_addr_r  <= held_addr_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
    if (advance && emit) begin
      out_is_write_r <= out_is_write_nxt;
      out_addr_r     <= out_addr_nxt;
      out_value_r    <= out_value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_write    = out_is_write_r;
  assign out_reg_address = out_addr_r;
  assign out_write_value = out_value_r;

endmodule

`default_nettype wire
